[hdl/pfde_pkg.sv]
// ----------------------------------------------------------------------------
// pfde_pkg
// Shared types and constants of the page framebuffer draw engine.
// ----------------------------------------------------------------------------
package pfde_pkg;

   localparam int Rows       = 64;
   localparam int Columns    = 128;
   localparam int BurstBytes = 8;
   localparam int Pages      = Rows / 8;
   localparam int StoreDepth = Pages * Columns;
   localparam int ColW       = $clog2(Columns);
   localparam int PageW      = $clog2(Pages);
   localparam int AddrW      = $clog2(StoreDepth);
   localparam int BeatW      = $clog2(BurstBytes);

   typedef enum logic [1:0] {
      CMD_PIXEL = 2'd0,
      CMD_VLINE = 2'd1,
      CMD_HLINE = 2'd2,
      CMD_FILL  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [5:0] row_a;
      logic [5:0] row_b;
      logic [6:0] col_a;
      logic [6:0] col_b;
      logic [2:0] page_sel;
      logic [7:0] fill_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  out_page;
      logic [6:0]  start_column;
      logic [3:0]  byte_count;
      logic [63:0] column_bytes;
      logic        last;
   } rsp_type;

   // One classified span of work: a single column run within one page.
   // fill set: overwrite with mask; else OR mask in.
   typedef struct packed {
      logic [PageW-1:0] page;
      logic [ColW-1:0]  first;
      logic [ColW-1:0]  final_col;
      logic [7:0]       mask;
      logic             fill;
      logic             last;
   } span_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_WAIT,
      ST_WRITE,
      ST_EMIT
   } back_state_type;

endpackage

[hdl/pfde_front.sv]
// ----------------------------------------------------------------------------
// pfde_front
// Accepts commands and breaks each one into page spans for the back end.
// ----------------------------------------------------------------------------
module pfde_front import pfde_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     span_valid,
   input  logic     span_stall,
   output span_type span_data
);

   logic            busy_ff, busy_in;
   logic [PageW-1:0] page_ff, page_in;
   logic [PageW-1:0] end_page_ff, end_page_in;
   logic [2:0]       lo_bit_ff, lo_bit_in;
   logic [2:0]       hi_bit_ff, hi_bit_in;
   logic [ColW-1:0]  col_ff, col_in;

   logic [5:0] lo_row, hi_row;
   logic [ColW-1:0] lo_col, hi_col;
   logic [7:0] hi_mask;

   // Sorted endpoints of the incoming command.
   always_comb begin
      lo_row = (req_data.row_a < req_data.row_b) ? req_data.row_a : req_data.row_b;
      hi_row = (req_data.row_a < req_data.row_b) ? req_data.row_b : req_data.row_a;
      lo_col = (req_data.col_a < req_data.col_b) ? req_data.col_a : req_data.col_b;
      hi_col = (req_data.col_a < req_data.col_b) ? req_data.col_b : req_data.col_a;
   end

   // Vertical line mask for the current page: the higher row bound applies on the last page.
   always_comb begin
      if (page_ff == end_page_ff) begin
         hi_mask = 8'hFF >> (3'd7 - hi_bit_ff);
      end else begin
         hi_mask = 8'hFF;
      end
   end

   logic [7:0] first_mask;
   assign first_mask = 8'hFF << lo_bit_ff;

   // Single-page commands pass directly; vertical lines iterate over pages.
   always_comb begin
      busy_in     = busy_ff;
      page_in     = page_ff;
      end_page_in = end_page_ff;
      lo_bit_in   = lo_bit_ff;
      hi_bit_in   = hi_bit_ff;
      col_in      = col_ff;
      span_valid  = 1'b0;
      span_data   = '0;
      req_stall   = busy_ff || span_stall;
      if (busy_ff) begin
         span_valid          = 1'b1;
         span_data.page      = page_ff;
         span_data.first     = col_ff;
         span_data.final_col = col_ff;
         span_data.mask      = first_mask & hi_mask;
         span_data.last      = (page_ff == end_page_ff);
         if (!span_stall) begin
            page_in   = page_ff + 1'b1;
            lo_bit_in = 3'd0;
            if (page_ff == end_page_ff) begin
               busy_in = 1'b0;
            end
         end
      end else if (req_valid) begin
         unique case (cmd_type'(req_data.cmd))
            CMD_PIXEL: begin
               span_valid          = 1'b1;
               span_data.page      = req_data.row_a[5:3];
               span_data.first     = req_data.col_a;
               span_data.final_col = req_data.col_a;
               span_data.mask      = 8'h01 << req_data.row_a[2:0];
               span_data.last      = 1'b1;
            end
            CMD_HLINE: begin
               span_valid          = 1'b1;
               span_data.page      = req_data.row_a[5:3];
               span_data.first     = lo_col;
               span_data.final_col = hi_col;
               span_data.mask      = 8'h01 << req_data.row_a[2:0];
               span_data.last      = 1'b1;
            end
            CMD_FILL: begin
               span_valid          = 1'b1;
               span_data.page      = req_data.page_sel;
               span_data.first     = '0;
               span_data.final_col = ColW'(Columns - 1);
               span_data.mask      = req_data.fill_byte;
               span_data.fill      = 1'b1;
               span_data.last      = 1'b1;
            end
            CMD_VLINE: begin
               if (!span_stall) begin
                  busy_in     = 1'b1;
                  page_in     = lo_row[5:3];
                  end_page_in = hi_row[5:3];
                  lo_bit_in   = lo_row[2:0];
                  hi_bit_in   = hi_row[2:0];
                  col_in      = req_data.col_a;
               end
            end
            default: ;
         endcase
      end
   end

   // Page walker registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      page_ff     <= page_in;
      end_page_ff <= end_page_in;
      lo_bit_ff   <= lo_bit_in;
      hi_bit_ff   <= hi_bit_in;
      col_ff      <= col_in;
   end

endmodule

[hdl/pfde_queue.sv]
// ----------------------------------------------------------------------------
// pfde_queue
// Two-entry queue of spans between the front and the back end.
// ----------------------------------------------------------------------------
module pfde_queue import pfde_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_stall,
   input  span_type in_data,
   output logic     out_valid,
   input  logic     out_stall,
   output span_type out_data
);

   span_type   slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_stall  = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   // Pointer and occupancy update.
   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

[hdl/pfde_back.sv]
// ----------------------------------------------------------------------------
// pfde_back
// Carries out spans: read-modify-write of the frame store, column by
// column, and collects the new bytes into bursts.
// ----------------------------------------------------------------------------
module pfde_back import pfde_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     span_valid,
   output logic     span_stall,
   input  span_type span_data,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic [7:0] store_mem [StoreDepth];
   logic [7:0] rd_data_ff;

   back_state_type   state_ff, state_in;
   span_type         span_ff, span_in;
   logic [ColW-1:0]  col_ff, col_in;
   logic [ColW-1:0]  start_ff, start_in;
   logic [BeatW:0]   cnt_ff, cnt_in;
   logic [63:0]      bytes_ff, bytes_in;
   logic [AddrW-1:0] clr_ff, clr_in;
   rsp_type          out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   logic             we;
   logic [AddrW-1:0] addr;
   logic [7:0]       wdata, new_byte;
   logic             span_done, burst_full;

   assign new_byte   = span_ff.fill ? span_ff.mask : (rd_data_ff | span_ff.mask);
   assign span_done  = (col_ff == span_ff.final_col);
   assign burst_full = (cnt_ff == (BeatW + 1)'(BurstBytes - 1));
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      span_in      = span_ff;
      col_in       = col_ff;
      start_in     = start_ff;
      cnt_in       = cnt_ff;
      bytes_in     = bytes_ff;
      clr_in       = clr_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      span_stall   = 1'b1;
      we           = 1'b0;
      addr         = {span_ff.page, col_ff};
      wdata        = new_byte;
      unique case (state_ff)
         ST_CLEAR: begin
            we    = 1'b1;
            addr  = clr_ff;
            wdata = 8'h00;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AddrW'(StoreDepth - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            span_stall = 1'b0;
            if (span_valid) begin
               span_in  = span_data;
               col_in   = span_data.first;
               start_in = span_data.first;
               cnt_in   = '0;
               bytes_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            we = 1'b1;
            bytes_in = bytes_ff | ({56'd0, new_byte} << {cnt_ff[BeatW-1:0], 3'b000});
            cnt_in   = cnt_ff + 1'b1;
            if (span_done || burst_full) begin
               state_in = ST_EMIT;
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in         = 1'b1;
               out_in.out_page      = 3'(span_ff.page);
               out_in.start_column  = 7'(start_ff);
               out_in.byte_count    = 4'(cnt_ff);
               out_in.column_bytes  = bytes_ff;
               out_in.last          = span_done && span_ff.last;
               cnt_in   = '0;
               bytes_in = '0;
               if (span_done) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + 1'b1;
                  start_in = col_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Frame store.
   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[addr] <= wdata;
      end
      rd_data_ff <= store_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
      span_ff  <= span_in;
      col_ff   <= col_in;
      start_ff <= start_in;
      cnt_ff   <= cnt_in;
      bytes_ff <= bytes_in;
      out_ff   <= out_in;
   end

endmodule

[hdl/page_framebuffer_draw_engine.sv]
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Draws pixels, lines and page fills into a page-organized monochrome frame
// store and reports the new column bytes in bursts.
// ----------------------------------------------------------------------------
// Usage: a command transfers on the req_ channel when req_valid is high and
// req_stall is low. Each command yields one or more bursts on the rsp_
// channel, the final one flagged by last. The front end splits vertical
// lines into one span per page; a two-entry queue decouples it from the back
// end, which does a read-modify-write of the single-port frame store.
// Each span is loaded, then every column byte takes a read, a wait and a
// write, and each burst is emitted in its own step; the frame store port
// sets this pace.
// After reset the back end clears all 1024 store bytes, one per cycle,
// before it takes the first command. When rsp_stall is high the output
// register holds its burst and the back end waits; commands keep queueing
// until the queue is full, then req_stall rises.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine import pfde_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     f_valid, f_stall, b_valid, b_stall;
   span_type f_span, b_span;

   pfde_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .span_valid(f_valid), .span_stall(f_stall), .span_data(f_span)
   );

   pfde_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_data(f_span),
      .out_valid(b_valid), .out_stall(b_stall), .out_data(b_span)
   );

   pfde_back u_back (
      .clock, .reset,
      .span_valid(b_valid), .span_stall(b_stall), .span_data(b_span),
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the page framebuffer draw engine. A directed
// table covers pixel, line and fill extremes; random commands follow. Every
// burst is compared with a frame-store predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
   import pfde_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Directed row: a command, and optionally the one burst it must produce.
   typedef struct {
      req_type cmd;
      bit      known;
      rsp_type burst;
   } row_type;

   logic [7:0] pix_mem [StoreDepth];
   rsp_type    burst_q [$];
   int         fail_count;
   int         send_idle_pct;
   int         recv_stall_pct;
   bit         sending;

   page_framebuffer_draw_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Clock with a period of 10.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Queue the bursts of one column span of a page.
   task automatic queue_span(input int pg, input int first, input int fin);
      int      col;
      int      cnt;
      rsp_type b;
      col = first;
      while (col <= fin) begin
         cnt = fin - col + 1;
         if (cnt > BurstBytes) cnt = BurstBytes;
         b = '0;
         b.out_page     = pg[2:0];
         b.start_column = col[6:0];
         b.byte_count   = cnt[3:0];
         for (int i = 0; i < cnt; i++)
            b.column_bytes[8*i +: 8] = pix_mem[pg*Columns + col + i];
         burst_q.push_back(b);
         col += cnt;
      end
   endtask

   // Update the store and queue the bursts a command causes.
   task automatic draw_and_predict(input req_type c);
      int ra, rb, ca, cb, lo, hi, sp, ep, lb, hb;
      logic [7:0] m;
      ra = c.row_a;
      rb = c.row_b;
      ca = c.col_a;
      cb = c.col_b;
      case (cmd_type'(c.cmd))
         CMD_PIXEL: begin
            pix_mem[(ra >> 3)*Columns + ca] |= 8'h01 << (ra & 7);
            queue_span(ra >> 3, ca, ca);
         end
         CMD_VLINE: begin
            lo = (ra < rb) ? ra : rb;
            hi = (ra < rb) ? rb : ra;
            sp = lo >> 3;
            ep = hi >> 3;
            for (int p = sp; p <= ep; p++) begin
               lb = (p == sp) ? (lo & 7) : 0;
               hb = (p == ep) ? (hi & 7) : 7;
               m  = (8'hFF << lb) & (8'hFF >> (7 - hb));
               pix_mem[p*Columns + ca] |= m;
               queue_span(p, ca, ca);
            end
         end
         CMD_HLINE: begin
            lo = (ca < cb) ? ca : cb;
            hi = (ca < cb) ? cb : ca;
            for (int x = lo; x <= hi; x++)
               pix_mem[(ra >> 3)*Columns + x] |= 8'h01 << (ra & 7);
            queue_span(ra >> 3, lo, hi);
         end
         default: begin
            for (int x = 0; x < Columns; x++)
               pix_mem[c.page_sel*Columns + x] = c.fill_byte;
            queue_span(c.page_sel, 0, Columns - 1);
         end
      endcase
      burst_q[$].last = 1'b1;
   endtask

   // Build a random command; most hit small spans to keep the run short.
   function automatic req_type rand_cmd();
      req_type c;
      c = req_type'(($bits(req_type))'({$urandom, $urandom}));
      if ($urandom_range(99) < 30) c.cmd = CMD_PIXEL;
      else if ($urandom_range(99) < 45) c.cmd = CMD_VLINE;
      else if ($urandom_range(99) < 85) c.cmd = CMD_HLINE;
      else c.cmd = CMD_FILL;
      if (c.cmd == CMD_HLINE && $urandom_range(3) != 0)
         c.col_b = c.col_a + 7'($urandom_range(20)) - 7'd10;
      return c;
   endfunction

   // Offer one command and hold it until it transfers.
   task automatic send_cmd(input req_type c);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      draw_and_predict(c);
   endtask

   // Compare each transfer on the result side with the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (burst_q.size() == 0) begin
               $error("unexpected burst %p", rsp_data);
               fail_count++;
            end else begin
               e = burst_q.pop_front();
               if (rsp_data.out_page !== e.out_page) begin
                  $error("out_page exp %0d got %0d", e.out_page, rsp_data.out_page);
                  fail_count++;
               end
               if (rsp_data.start_column !== e.start_column) begin
                  $error("start_column exp %0d got %0d", e.start_column,
                         rsp_data.start_column);
                  fail_count++;
               end
               if (rsp_data.byte_count !== e.byte_count) begin
                  $error("byte_count exp %0d got %0d", e.byte_count,
                         rsp_data.byte_count);
                  fail_count++;
               end
               if (rsp_data.column_bytes !== e.column_bytes) begin
                  $error("column_bytes exp %h got %h", e.column_bytes,
                         rsp_data.column_bytes);
                  fail_count++;
               end
               if (rsp_data.last !== e.last) begin
                  $error("last exp %0d got %0d", e.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
         rsp_stall <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   // Directed table, then random phases with varying idle patterns.
   initial begin
      row_type tbl [$];
      row_type r;
      int      dir_fail;
      int      guard;
      fail_count     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      for (int i = 0; i < StoreDepth; i++) pix_mem[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Pixel at origin and far corner: single-bit bytes read off directly.
      r = '{cmd: '{CMD_PIXEL, 6'd0, 6'd0, 7'd0, 7'd0, 3'd0, 8'd0}, known: 1,
            burst: '{3'd0, 7'd0, 4'd1, 64'h01, 1'b1}};
      tbl.push_back(r);
      r = '{cmd: '{CMD_PIXEL, 6'd63, 6'h2A, 7'd127, 7'd5, 3'd7, 8'hFF}, known: 1,
            burst: '{3'd7, 7'd127, 4'd1, 64'h80, 1'b1}};
      tbl.push_back(r);
      r = '{cmd: '{CMD_FILL, 6'h3F, 6'h3F, 7'h7F, 7'h7F, 3'd3, 8'hA5}, known: 0,
            burst: '0};
      tbl.push_back(r);
      r = '{cmd: '{CMD_FILL, 6'd0, 6'd0, 7'd0, 7'd0, 3'd7, 8'h00}, known: 0,
            burst: '0};
      tbl.push_back(r);
      r = '{cmd: '{CMD_VLINE, 6'd63, 6'd0, 7'd127, 7'd0, 3'd0, 8'd0}, known: 0,
            burst: '0};
      tbl.push_back(r);
      r = '{cmd: '{CMD_VLINE, 6'd10, 6'd10, 7'd5, 7'd0, 3'd0, 8'd0}, known: 0,
            burst: '0};
      tbl.push_back(r);
      r = '{cmd: '{CMD_VLINE, 6'd9, 6'd22, 7'd64, 7'd0, 3'd0, 8'd0}, known: 0,
            burst: '0};
      tbl.push_back(r);
      r = '{cmd: '{CMD_HLINE, 6'd20, 6'd0, 7'd127, 7'd0, 3'd0, 8'd0}, known: 0,
            burst: '0};
      tbl.push_back(r);
      r = '{cmd: '{CMD_HLINE, 6'd63, 6'd0, 7'd3, 7'd3, 3'd0, 8'd0}, known: 0,
            burst: '0};
      tbl.push_back(r);
      r = '{cmd: '{CMD_HLINE, 6'd1, 6'd0, 7'd9, 7'd18, 3'd0, 8'd0}, known: 0,
            burst: '0};
      tbl.push_back(r);
      r = '{cmd: '{CMD_PIXEL, 6'd35, 6'd0, 7'd64, 7'd0, 3'd0, 8'd0}, known: 0,
            burst: '0};
      tbl.push_back(r);
      r = '{cmd: '{CMD_FILL, 6'd0, 6'd0, 7'd0, 7'd0, 3'd0, 8'hFF}, known: 0,
            burst: '0};
      tbl.push_back(r);

      // A known row makes exactly one burst, the newest one queued.
      foreach (tbl[i]) begin
         send_cmd(tbl[i].cmd);
         if (tbl[i].known && burst_q[burst_q.size() - 1] !== tbl[i].burst) begin
            $error("directed row %0d: burst %p, table %p", i,
                   burst_q[burst_q.size() - 1], tbl[i].burst);
            fail_count++;
         end
      end

      // Random phases: none, sender idle, receiver stall, both.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 61 : (ph == 3) ? 12 : 0;
         recv_stall_pct = (ph == 2) ? 61 : (ph == 3) ? 12 : 0;
         for (int k = 0; k < 92; k++) send_cmd(rand_cmd());
      end
      req_valid <= 1'b0;

      // Drain, then allow a short settling window for stray bursts.
      recv_stall_pct = 0;
      guard = 0;
      while (burst_q.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (500) @(posedge clock);
      if (fail_count == 0 && burst_q.size() == 0)
         $display("page_framebuffer_draw_engine verification clean");
      else
         $display("page_framebuffer_draw_engine verification failed");
      $finish;
   end

   // Timeout.
   initial begin
      #20000000;
      $display("page_framebuffer_draw_engine verification failed");
      $finish;
   end

endmodule

[files.f]
hdl/pfde_pkg.sv
hdl/pfde_front.sv
hdl/pfde_queue.sv
hdl/pfde_back.sv
hdl/page_framebuffer_draw_engine.sv
dv/tb.sv
